@@ rtl/e2f_pkg.sv @@
// e2f_pkg: shared types, constants and calendar helpers for the epoch to fat timestamp block
// depends on nothing; used by e2f_ctrl, e2f_datapath and epoch_to_fat_timestamp
`timescale 1ns / 1ps
`default_nettype none

package e2f_pkg;

   // a day is 128 * 675 seconds; the count is shifted by 7 and divided by 675
   localparam logic [9:0]  SECS_PER_DAY_HI = 10'd675;
   // ceil(2^35 / 675), exact quotient for any 25-bit dividend
   localparam logic [25:0] DAY_RECIP      = 26'd50903317;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   // year offset from 2000 plus this bias gives the fat year offset from 1980
   localparam logic [7:0]  FAT_YEAR_BIAS  = 8'd20;
   // 2100 is the only century year reachable that breaks the four-year rule
   localparam logic [7:0]  NOLEAP_CENTURY = 8'd100;
   localparam logic [3:0]  MONTH_FEB      = 4'd1;
   localparam logic [3:0]  MONTH_LAST     = 4'd11;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DAYS,
      S_REM,
      S_YEAR,
      S_MONTH,
      S_PACK
   } state_type;

   typedef struct packed {
      logic load;
      logic div_days;
      logic div_rem;
      logic year_step;
      logic month_step;
      logic tod_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
      logic tod_done;
   } status_type;

   // year offset from 2000, valid for offsets below 200
   function automatic logic is_leap(input logic [7:0] yoff);
      return (yoff[1:0] == 2'b00) && (yoff != NOLEAP_CENTURY);
   endfunction

   function automatic logic [8:0] year_len(input logic [7:0] yoff);
      return is_leap(yoff) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      if (mon == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (mon inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

@@ rtl/e2f_datapath.sv @@
// e2f_datapath: day split, year and month walk, time-of-day split and result register
// depends on e2f_pkg; driven by e2f_ctrl through cmd_type, reports through status_type
`timescale 1ns / 1ps
`default_nettype none

module e2f_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [31:0]         req_epoch_seconds,
   input  wire e2f_pkg::cmd_type    cmd,
   output e2f_pkg::status_type      status,
   output logic [31:0]              rsp_fat_timestamp
);

   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [7:0]  yoff_ff, yoff_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic        phase_ff, phase_in;
   logic [31:0] out_ff, out_in;

   logic [24:0] day_hi;
   logic [50:0] day_prod;
   logic [15:0] day_quot;
   logic [25:0] day_back;
   logic [9:0]  day_rem;
   logic [15:0] days;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic        hour_ge;
   logic        min_ge;
   logic [7:0]  fat_year;
   logic [3:0]  fat_month;
   logic [4:0]  fat_day;

   // days by reciprocal multiply of the count over 128, then the 675 remainder
   // on top of the low 7 bits gives the second of the day
   assign day_hi   = quot_ff[31:7];
   assign day_prod = {26'd0, day_hi} * {25'd0, e2f_pkg::DAY_RECIP};
   assign day_quot = day_prod[50:35];
   assign day_back = {10'd0, rem_ff[15:0]} * {16'd0, e2f_pkg::SECS_PER_DAY_HI};
   assign day_rem  = 10'(day_hi - day_back[24:0]);

   assign days    = quot_ff[15:0];
   assign ylen    = e2f_pkg::year_len(yoff_ff);
   assign mlen    = e2f_pkg::month_len(mon_ff, e2f_pkg::is_leap(yoff_ff));
   assign hour_ge = rem_ff >= {5'd0, e2f_pkg::SECS_PER_HOUR};
   assign min_ge  = rem_ff >= {11'd0, e2f_pkg::SECS_PER_MIN};

   assign status.year_done  = days < {7'd0, ylen};
   assign status.month_done = (mon_ff == e2f_pkg::MONTH_LAST) || (days < {11'd0, mlen});
   assign status.tod_done   = phase_ff && !min_ge;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      yoff_in  = yoff_ff;
      mon_in   = mon_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      phase_in = phase_ff;
      if (cmd.load) begin
         quot_in  = req_epoch_seconds;
         rem_in   = 17'd0;
         yoff_in  = 8'd0;
         mon_in   = 4'd0;
         hour_in  = 5'd0;
         min_in   = 6'd0;
         phase_in = 1'b0;
      end else begin
         // day count parks in the remainder while the count is still needed
         if (cmd.div_days) begin
            rem_in = {1'b0, day_quot};
         end
         if (cmd.div_rem) begin
            quot_in = {16'd0, rem_ff[15:0]};
            rem_in  = {day_rem, quot_ff[6:0]};
         end
         if (cmd.year_step && !status.year_done) begin
            quot_in = {16'd0, 16'(days - {7'd0, ylen})};
            yoff_in = 8'(yoff_ff + 8'd1);
         end
         if (cmd.month_step && !status.month_done) begin
            quot_in = {16'd0, 16'(days - {11'd0, mlen})};
            mon_in  = 4'(mon_ff + 4'd1);
         end
         // hours first, then minutes, out of the second of the day
         if (cmd.tod_step) begin
            if (!phase_ff) begin
               if (hour_ge) begin
                  rem_in  = 17'(rem_ff - {5'd0, e2f_pkg::SECS_PER_HOUR});
                  hour_in = 5'(hour_ff + 5'd1);
               end else begin
                  phase_in = 1'b1;
               end
            end else if (min_ge) begin
               rem_in = 17'(rem_ff - {11'd0, e2f_pkg::SECS_PER_MIN});
               min_in = 6'(min_ff + 6'd1);
            end
         end
      end
   end

   assign fat_year  = 8'(yoff_ff + e2f_pkg::FAT_YEAR_BIAS);
   assign fat_month = 4'(mon_ff + 4'd1);
   assign fat_day   = 5'(days[4:0] + 5'd1);

   always_comb begin
      out_in = out_ff;
      if (cmd.out_load) begin
         out_in = {fat_year[6:0], fat_month, fat_day, hour_ff, min_ff, rem_ff[5:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= 17'd0;
         mon_ff   <= 4'd0;
         hour_ff  <= 5'd0;
         min_ff   <= 6'd0;
         phase_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         mon_ff   <= mon_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      yoff_ff <= yoff_in;
      out_ff  <= out_in;
   end

   assign rsp_fat_timestamp = out_ff;

`ifndef SYNTH
   a_mon_range: assert property (@(posedge clock) disable iff (reset)
      mon_ff <= e2f_pkg::MONTH_LAST)
      else $error("month counter past december");
   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff < 5'd24)
      else $error("hour counter past 23");
   a_tod_rem: assert property (@(posedge clock) disable iff (reset)
      status.tod_done |-> (rem_ff < {11'd0, e2f_pkg::SECS_PER_MIN}) && (min_ff < 6'd60))
      else $error("time of day split left an out of range minute or second");
`endif

endmodule

`default_nettype wire

@@ rtl/e2f_ctrl.sv @@
// e2f_ctrl: sequencing state machine and result valid flag
// depends on e2f_pkg; commands e2f_datapath through cmd_type
`timescale 1ns / 1ps
`default_nettype none

module e2f_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire e2f_pkg::status_type  status,
   output e2f_pkg::cmd_type          cmd
);

   e2f_pkg::state_type state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         e2f_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = e2f_pkg::S_DAYS;
            end
         end
         e2f_pkg::S_DAYS: begin
            state_in = e2f_pkg::S_REM;
         end
         e2f_pkg::S_REM: begin
            state_in = e2f_pkg::S_YEAR;
         end
         e2f_pkg::S_YEAR: begin
            if (status.year_done) begin
               state_in = e2f_pkg::S_MONTH;
            end
         end
         e2f_pkg::S_MONTH: begin
            if (status.month_done) begin
               state_in = e2f_pkg::S_PACK;
            end
         end
         e2f_pkg::S_PACK: begin
            if (status.tod_done && out_free) begin
               state_in = e2f_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = e2f_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         e2f_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         e2f_pkg::S_DAYS: begin
            cmd.div_days = 1'b1;
         end
         e2f_pkg::S_REM: begin
            cmd.div_rem = 1'b1;
         end
         e2f_pkg::S_YEAR: begin
            cmd.year_step = 1'b1;
            cmd.tod_step  = 1'b1;
         end
         e2f_pkg::S_MONTH: begin
            cmd.month_step = 1'b1;
            cmd.tod_step   = 1'b1;
         end
         e2f_pkg::S_PACK: begin
            cmd.tod_step = 1'b1;
            cmd.out_load = status.tod_done && out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= e2f_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a response is still pending");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == e2f_pkg::S_DAYS))
      else $error("accepted request did not start the day split");
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == e2f_pkg::S_REM) |=> state_ff == e2f_pkg::S_YEAR)
      else $error("day split did not hand over after its second cycle");
`endif

endmodule

`default_nettype wire

@@ rtl/epoch_to_fat_timestamp.sv @@
// epoch_to_fat_timestamp: seconds since 2000-01-01 to fat packed date-time word
// depends on e2f_pkg, e2f_ctrl and e2f_datapath
//
//   channel  | direction | ports
//   request  | in        | req_valid, req_ready, req_epoch_seconds[31:0]
//   response | out       | rsp_valid, rsp_ready, rsp_fat_timestamp[31:0]
//
// one request at a time: an accept state, a day split and a second-of-day split, then a
// year walk with one step per year walked plus one, a month walk with one step per month
// walked plus one, and a pack state that waits for the time-of-day split and a free result register
// the hour/minute split runs beside the year and month walk and on into the pack state,
// so for early dates it, not the year walk, sets the length
// a finished response waits in its own register; the next request is taken meanwhile,
// but its pack cycle stalls until that register is free
// synchronous active-high reset clears the controller and any pending response
`timescale 1ns / 1ps
`default_nettype none

module epoch_to_fat_timestamp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_fat_timestamp
);

   e2f_pkg::cmd_type    cmd;
   e2f_pkg::status_type status;

   e2f_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   e2f_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_epoch_seconds (req_epoch_seconds),
      .cmd               (cmd),
      .status            (status),
      .rsp_fat_timestamp (rsp_fat_timestamp)
   );

endmodule

`default_nettype wire

@@ tb/sv/epoch_to_fat_timestamp_tb.sv @@
// epoch_to_fat_timestamp_tb: self-checking bench for the epoch seconds to fat date-time block
// drives a directed calendar table then random requests under several idle mixes, predicts the
// words the table lacks with a year/month walk of its own; needs all four rtl files
`timescale 1ns / 1ps

module epoch_to_fat_timestamp_tb;

   localparam int unsigned DAY_SECS  = 86400;
   localparam int unsigned HOUR_SECS = 3600;
   localparam int unsigned EPOCH_YEAR = 2000;
   localparam int unsigned FAT_EPOCH  = 1980;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned LAST_DAY  = 49709;   // last day index that still fits 86399 more seconds
   localparam int PHASE_ITEMS = 190;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [31:0] secs;
      logic        known;
      logic [31:0] word;
   } date_case_type;

   localparam int DATE_CASE_N = 22;
   localparam date_case_type DATE_CASES [DATE_CASE_N] = '{
      '{32'd0,                           1'b1, 32'h2821_0000},  // epoch start
      '{32'd1,                           1'b1, 32'h2821_0000},  // odd second rounds down
      '{32'd2,                           1'b1, 32'h2821_0001},
      '{32'd3,                           1'b1, 32'h2821_0001},
      '{32'd86399,                       1'b1, 32'h2821_BF7D},  // last second of first day
      '{32'd86400,                       1'b1, 32'h2822_0000},
      '{32'd59 * 32'd86400,              1'b0, 32'h0},          // 2000 leap day
      '{32'd60 * 32'd86400,              1'b0, 32'h0},
      '{32'd366 * 32'd86400 - 32'd1,     1'b0, 32'h0},
      '{32'd366 * 32'd86400,             1'b0, 32'h0},
      '{32'd36583 * 32'd86400,           1'b0, 32'h0},          // 2100 is not a leap year
      '{32'd36584 * 32'd86400,           1'b0, 32'h0},
      '{32'd39446 * 32'd86400 - 32'd1,   1'b1, 32'hFF9F_BF7D},  // end of 2107, offset 127
      '{32'd39446 * 32'd86400,           1'b1, 32'h0021_0000},  // 2108 wraps the year field
      '{32'hFFFF_FFFF,                   1'b1, 32'h3847_3387},
      '{32'h8000_0000,                   1'b0, 32'h0},
      '{32'h7FFF_FFFF,                   1'b0, 32'h0},
      '{32'h5555_5555,                   1'b0, 32'h0},
      '{32'hAAAA_AAAA,                   1'b0, 32'h0},
      '{32'd30 * 32'd86400 + 32'd45296,  1'b0, 32'h0},
      '{32'd8825 * 32'd86400,            1'b0, 32'h0},          // 2024 leap day
      '{32'd38044 * 32'd86400,           1'b0, 32'h0}           // 2104 leap day
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_fat_timestamp;

   logic [31:0] fat_expected_q [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold_left = 0;

   epoch_to_fat_timestamp dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fat_timestamp (rsp_fat_timestamp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("[epoch_to_fat_timestamp] ERROR");
      $finish;
   end

   function automatic logic gregorian_leap(input int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   // walk years then months from 2000, then pack the fat date-time word
   function automatic logic [31:0] fat_word_of(input logic [31:0] secs);
      int unsigned days;
      int unsigned tod;
      int unsigned year;
      int unsigned mon;
      int unsigned span;
      logic [6:0]  yoff;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [4:0]  half_sec;
      days = secs / DAY_SECS;
      tod  = secs % DAY_SECS;
      year = EPOCH_YEAR;
      mon  = 0;
      while (1) begin
         span = gregorian_leap(year) ? 366 : 365;
         if (days < span) break;
         days -= span;
         year++;
      end
      while (mon < 11) begin
         span = MONTH_DAYS[mon] + ((mon == 1 && gregorian_leap(year)) ? 1 : 0);
         if (days < span) break;
         days -= span;
         mon++;
      end
      yoff     = 7'(year - FAT_EPOCH);
      month    = 4'(mon + 1);
      mday     = 5'(days + 1);
      hour     = 5'(tod / HOUR_SECS);
      minute   = 6'((tod % HOUR_SECS) / 60);
      half_sec = 5'((tod % 60) / 2);
      return {yoff, month, mday, hour, minute, half_sec};
   endfunction

   function automatic logic chance(input int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // half plain random, a quarter on midnight or the last second of a day, a quarter early years
   function automatic logic [31:0] pick_epoch();
      int unsigned days;
      logic [31:0] secs;
      case ($urandom_range(3, 0))
         0, 1: begin
            secs = $urandom();
         end
         2: begin
            days = $urandom_range(LAST_DAY, 0);
            secs = days * DAY_SECS + ($urandom_range(1, 0) ? DAY_SECS - 1 : 0);
         end
         default: begin
            secs = $urandom_range(400_000_000, 0);
         end
      endcase
      return secs;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch %s: expected %08h got %08h at %0t", what, want, got, $realtime);
      mismatch_count++;
   endtask

   // entered at a falling edge, returns at the falling edge after the request is taken
   task automatic offer_request(input logic [31:0] secs, input logic [31:0] word);
      if (chance(send_idle_pct)) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (chance(send_idle_pct));
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      fat_expected_q.push_back(word);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready <= !chance(rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (fat_expected_q.size() == 0) begin
            report_mismatch("unexpected response", 32'h0, rsp_fat_timestamp);
         end else if (rsp_fat_timestamp !== fat_expected_q[0]) begin
            report_mismatch("fat_timestamp", fat_expected_q[0], rsp_fat_timestamp);
            void'(fat_expected_q.pop_front());
         end else begin
            void'(fat_expected_q.pop_front());
         end
      end
   end

   initial begin
      logic [31:0] secs;
      logic [31:0] word;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DATE_CASES[i]) begin
         word = DATE_CASES[i].known ? DATE_CASES[i].word : fat_word_of(DATE_CASES[i].secs);
         offer_request(DATE_CASES[i].secs, word);
      end

      // idle mixes: none, sender only, receiver only, both light
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 57 : (phase == 3) ? 8 : 0;
         rsp_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 8 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while requests keep coming, so the input backs up
            if (phase == 0 && n == 40) rsp_hold_left = HOLD_CYCLES;
            // sender pause until every response is back
            if (phase == 1 && n == 100) begin
               req_valid <= 1'b0;
               do @(negedge clock); while (fat_expected_q.size() != 0);
            end
            secs = pick_epoch();
            offer_request(secs, fat_word_of(secs));
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (fat_expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && fat_expected_q.size() == 0) begin
         $display("[epoch_to_fat_timestamp] OK");
      end else begin
         $display("[epoch_to_fat_timestamp] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/e2f_pkg.sv
rtl/e2f_datapath.sv
rtl/e2f_ctrl.sv
rtl/epoch_to_fat_timestamp.sv
tb/sv/epoch_to_fat_timestamp_tb.sv
